// ----- src/mtxinv_pkg.sv -----
// ----------------------------------------------------------------------------
// mtxinv_pkg: shared types, constants and microprogram for the 4x4 inverse
// Holds the widths of the exact cofactor arithmetic, the controller/datapath
// command types and the cofactor/determinant microprogram table.
// ----------------------------------------------------------------------------
package mtxinv_pkg;

   // element and register formats
   localparam int ELEM_W            = 32;
   localparam int THR_W             = 31;
   localparam int ELEMS             = 16;
   localparam int ADDR_W            = 4;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam logic [THR_W-1:0] THR_RESET = 31'd1;

   // exact arithmetic widths
   localparam int LIMB_W  = 32;                 // multiplier slice of the wide operand
   localparam int X_W     = 4 * LIMB_W;         // wide operand register
   localparam int PROD_W  = LIMB_W + 1 + ELEM_W; // signed 33x32 product
   localparam int MINOR_W = 2 * ELEM_W + 1;     // 2x2 minor
   localparam int COF_W   = MINOR_W + ELEM_W;   // 3x3 cofactor (3 terms)
   localparam int ACC_W   = COF_W + ELEM_W + 1; // determinant (4 terms)
   localparam int Q_W     = 32;                 // quotient bits
   localparam int DIV_W   = ACC_W + Q_W;        // divider datapath
   localparam int NREG    = 16;                 // minor / cofactor slots
   localparam int PC_W    = 9;

   localparam logic [Q_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [Q_W-1:0] SAT_MIN = 32'h8000_0000;

   // microprogram instruction kinds
   typedef enum logic [3:0] {
      PK_NOP,
      PK_CLR,
      PK_LDXE,
      PK_LDXM,
      PK_LDXC,
      PK_MAC,
      PK_STM,
      PK_STC,
      PK_STD,
      PK_END
   } prog_kind_type;

   typedef struct packed {
      prog_kind_type     kind;
      logic [ADDR_W-1:0] addr;       // element address
      logic [3:0]        idx;        // minor / cofactor slot
      logic              sub;        // subtract product from accumulator
      logic [1:0]        last_limb;  // index of the signed top limb
   } prog_op_type;

   // datapath commands
   typedef enum logic [4:0] {
      DP_NONE,
      DP_CLR,
      DP_LDXE,
      DP_LDXM,
      DP_LDXC,
      DP_MUL,
      DP_ACC,
      DP_STM,
      DP_STC,
      DP_STD,
      DP_MAG,
      DP_TEST,
      DP_DIV_INIT,
      DP_DIV_CHK,
      DP_DIV_STEP,
      DP_OUT_DIV,
      DP_OUT_ECHO
   } dp_op_type;

   typedef struct packed {
      dp_op_type         op;
      logic              ram_we;
      logic [ADDR_W-1:0] ram_waddr;
      logic              ram_re;
      logic [ADDR_W-1:0] ram_raddr;
      logic [3:0]        idx;
      logic              sub;
      logic [1:0]        limb;
      logic              top;
      logic              last;
   } dp_cmd_type;

   typedef struct packed {
      logic singular;
   } dp_status_type;

   // column pairs of a 2x2 minor: 01 02 03 12 13 23
   function automatic logic [1:0] pair_lo(input logic [2:0] p);
      case (p)
         3'd0, 3'd1, 3'd2: pair_lo = 2'd0;
         3'd3, 3'd4:       pair_lo = 2'd1;
         default:          pair_lo = 2'd2;
      endcase
   endfunction

   function automatic logic [1:0] pair_hi(input logic [2:0] p);
      case (p)
         3'd0:       pair_hi = 2'd1;
         3'd1, 3'd3: pair_hi = 2'd2;
         default:    pair_hi = 2'd3;
      endcase
   endfunction

   function automatic logic [2:0] pair_idx(input logic [1:0] a, input logic [1:0] b);
      case ({a, b})
         4'b0001: pair_idx = 3'd0;
         4'b0010: pair_idx = 3'd1;
         4'b0011: pair_idx = 3'd2;
         4'b0110: pair_idx = 3'd3;
         4'b0111: pair_idx = 3'd4;
         default: pair_idx = 3'd5;
      endcase
   endfunction

   // Microprogram. pc[8:7]=00: 2x2 minors (8 slots each),
   // 01: cofactors (8 slots each), 1x: determinant then end.
   function automatic prog_op_type prog_op(input logic [PC_W-1:0] pc);
      logic [3:0]  m;
      logic [2:0]  slot;
      logic [1:0]  r0, r1, c0, c1, i, j, row, k1, k2, k3;
      logic        s, cneg;
      prog_op_type op;
      m    = pc[6:3];
      slot = pc[2:0];
      op   = '{kind: PK_NOP, addr: '0, idx: '0, sub: 1'b0, last_limb: 2'd0};
      s    = m[3];
      r0   = s ? 2'd0 : 2'd2;
      r1   = s ? 2'd1 : 2'd3;
      c0   = pair_lo(m[2:0]);
      c1   = pair_hi(m[2:0]);
      i    = m[3:2];
      j    = m[1:0];
      row  = i ^ 2'd1;
      cneg = i[0] ^ j[0];
      k1   = (j == 2'd0) ? 2'd1 : 2'd0;
      k2   = (j <= 2'd1) ? 2'd2 : 2'd1;
      k3   = (j == 2'd3) ? 2'd2 : 2'd3;
      if (!pc[8]) begin
         if (!pc[7]) begin
            // minor {s,p} = e(r0,c0)e(r1,c1) - e(r0,c1)e(r1,c0)
            if (m[2:0] <= 3'd5) begin
               case (slot)
                  3'd0: op.kind = PK_CLR;
                  3'd1: begin
                     op.kind = PK_LDXE;
                     op.addr = {r0, c0};
                  end
                  3'd2: begin
                     op.kind = PK_MAC;
                     op.addr = {r1, c1};
                  end
                  3'd3: begin
                     op.kind = PK_LDXE;
                     op.addr = {r0, c1};
                  end
                  3'd4: begin
                     op.kind = PK_MAC;
                     op.addr = {r1, c0};
                     op.sub  = 1'b1;
                  end
                  3'd5: begin
                     op.kind = PK_STM;
                     op.idx  = m;
                  end
                  default: op.kind = PK_NOP;
               endcase
            end
         end else begin
            // cofactor (i,j): three element x minor terms, signs + - +, all negated when i+j is odd
            case (slot)
               3'd0: op.kind = PK_CLR;
               3'd1: begin
                  op.kind = PK_LDXM;
                  op.idx  = {s, pair_idx(k2, k3)};
               end
               3'd2: begin
                  op.kind      = PK_MAC;
                  op.addr      = {row, k1};
                  op.sub       = cneg;
                  op.last_limb = 2'd2;
               end
               3'd3: begin
                  op.kind = PK_LDXM;
                  op.idx  = {s, pair_idx(k1, k3)};
               end
               3'd4: begin
                  op.kind      = PK_MAC;
                  op.addr      = {row, k2};
                  op.sub       = ~cneg;
                  op.last_limb = 2'd2;
               end
               3'd5: begin
                  op.kind = PK_LDXM;
                  op.idx  = {s, pair_idx(k1, k2)};
               end
               3'd6: begin
                  op.kind      = PK_MAC;
                  op.addr      = {row, k3};
                  op.sub       = cneg;
                  op.last_limb = 2'd2;
               end
               default: begin
                  op.kind = PK_STC;
                  op.idx  = m;
               end
            endcase
         end
      end else if (pc[7:4] == 4'd0) begin
         // determinant along row 0
         case (pc[3:0])
            4'd0: op.kind = PK_CLR;
            4'd1, 4'd3, 4'd5, 4'd7: begin
               op.kind = PK_LDXC;
               op.idx  = {2'd0, pc[2:1]};
            end
            4'd2, 4'd4, 4'd6, 4'd8: begin
               op.kind      = PK_MAC;
               op.addr      = {2'd0, pc[2:1] - 2'd1};
               op.last_limb = 2'd3;
            end
            4'd9:    op.kind = PK_STD;
            default: op.kind = PK_END;
         endcase
      end else begin
         op.kind = PK_END;
      end
      prog_op = op;
   endfunction

endpackage

// ----- src/matrix_inverse_4x4.sv -----
// ----------------------------------------------------------------------------
// matrix_inverse_4x4: adjugate/cofactor 4x4 inverse, signed fixed point
// Elements load one per cycle while req_ready is high. After the sixteenth
// element the cofactor microprogram (one 33x32 multiplier, one accumulator)
// runs; each result then comes from a 32-step divider (element if singular).
// Reset is synchronous: load count cleared, threshold set to 1, no result.
// ----------------------------------------------------------------------------
module matrix_inverse_4x4 #(
   parameter int FRAC_BITS = mtxinv_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [mtxinv_pkg::ELEM_W-1:0] req_element_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [mtxinv_pkg::Q_W-1:0]    rsp_result_value,
   output logic                                 rsp_is_singular,
   output logic                                 rsp_last_of_matrix,
   input  logic                                 csr_write_enable,
   input  logic [mtxinv_pkg::THR_W-1:0]         csr_write_data
);

   mtxinv_pkg::dp_cmd_type    cmd;
   mtxinv_pkg::dp_status_type status;

   // sequencing
   mtxinv_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd      (cmd),
      .status   (status)
   );

   // arithmetic and storage
   mtxinv_dp #(
      .FRAC_BITS(FRAC_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_element_value (req_element_value),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_result_value  (rsp_result_value),
      .rsp_is_singular   (rsp_is_singular),
      .rsp_last_of_matrix(rsp_last_of_matrix)
   );

endmodule

// ----- src/mtxinv_ram.sv -----
// ----------------------------------------------------------------------------
// mtxinv_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mtxinv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, held when idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/mtxinv_dp.sv -----
// ----------------------------------------------------------------------------
// mtxinv_dp: datapath of the 4x4 inverse
// Element RAM, 33x32 limb multiplier with wide accumulator, minor and
// cofactor files, singular test, radix-2 divider and result register.
// ----------------------------------------------------------------------------
module mtxinv_dp #(
   parameter int FRAC_BITS = mtxinv_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mtxinv_pkg::dp_cmd_type              cmd,
   output mtxinv_pkg::dp_status_type           status,
   input  logic signed [mtxinv_pkg::ELEM_W-1:0] req_element_value,
   input  logic                                csr_write_enable,
   input  logic [mtxinv_pkg::THR_W-1:0]        csr_write_data,
   output logic signed [mtxinv_pkg::Q_W-1:0]   rsp_result_value,
   output logic                                rsp_is_singular,
   output logic                                rsp_last_of_matrix
);

   localparam int ELEM_W  = mtxinv_pkg::ELEM_W;
   localparam int LIMB_W  = mtxinv_pkg::LIMB_W;
   localparam int X_W     = mtxinv_pkg::X_W;
   localparam int PROD_W  = mtxinv_pkg::PROD_W;
   localparam int MINOR_W = mtxinv_pkg::MINOR_W;
   localparam int COF_W   = mtxinv_pkg::COF_W;
   localparam int ACC_W   = mtxinv_pkg::ACC_W;
   localparam int DIV_W   = mtxinv_pkg::DIV_W;
   localparam int Q_W     = mtxinv_pkg::Q_W;
   localparam int THR_W   = mtxinv_pkg::THR_W;
   localparam int NREG    = mtxinv_pkg::NREG;
   localparam int TEST_SH = 3 * FRAC_BITS;
   localparam int NUM_SH  = 2 * FRAC_BITS;

   logic [ELEM_W-1:0]       rdata;
   logic [ACC_W-1:0]        acc_ff;
   logic [X_W-1:0]          x_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [1:0]              limb_sh_ff;
   logic                    sub_ff;
   logic [MINOR_W-1:0]      minor_ff [NREG];
   logic [COF_W-1:0]        cof_ff [NREG];
   logic [ACC_W-1:0]        det_ff;
   logic [ACC_W-1:0]        mag_ff;
   logic                    detneg_ff;
   logic                    sing_ff;
   logic [THR_W-1:0]        thr_ff;
   logic [DIV_W-1:0]        rem_ff;
   logic [DIV_W-1:0]        dsh_ff;
   logic [Q_W-1:0]          q_ff;
   logic                    big_ff;
   logic                    neg_ff;
   logic [Q_W-1:0]          res_ff;
   logic                    rsing_ff;
   logic                    last_ff;

   logic [LIMB_W-1:0]        limb_bits;
   logic signed [LIMB_W:0]   mcand;
   logic signed [ELEM_W-1:0] mplier;
   logic signed [PROD_W-1:0] prod_in;
   logic [ACC_W-1:0]         addend;
   logic [ACC_W-1:0]         acc_in;
   logic [MINOR_W-1:0]       minor_sel;
   logic [COF_W-1:0]         cof_sel;
   logic [COF_W-1:0]         cof_abs;
   logic [ACC_W-1:0]         det_abs;
   logic [ACC_W-1:0]         mag_shr;
   logic                     sing_in;
   logic                     rem_ge;
   logic [Q_W-1:0]           res_in;

   // element store
   mtxinv_ram #(
      .WIDTH(ELEM_W),
      .DEPTH(mtxinv_pkg::ELEMS)
   ) u_elem_ram (
      .clock  (clock),
      .wr_en  (cmd.ram_we),
      .wr_addr(cmd.ram_waddr),
      .wr_data(req_element_value),
      .rd_en  (cmd.ram_re),
      .rd_addr(cmd.ram_raddr),
      .rd_data(rdata)
   );

   // limb multiply: unsigned lower limbs, signed top limb
   assign limb_bits = x_ff[{cmd.limb, 5'd0} +: LIMB_W];
   assign mcand     = {(cmd.top & limb_bits[LIMB_W-1]), limb_bits};
   assign mplier    = rdata;
   assign prod_in   = mcand * mplier;

   // weighted product into the accumulator
   assign addend = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff} << {limb_sh_ff, 5'd0};
   assign acc_in = sub_ff ? (acc_ff - addend) : (acc_ff + addend);

   assign minor_sel = minor_ff[cmd.idx];
   assign cof_sel   = cof_ff[cmd.idx];
   assign cof_abs   = cof_sel[COF_W-1] ? (~cof_sel + 1'b1) : cof_sel;
   assign det_abs   = det_ff[ACC_W-1] ? (~det_ff + 1'b1) : det_ff;

   // singular: zero determinant, or scaled magnitude below threshold
   assign mag_shr = mag_ff >> TEST_SH;
   assign sing_in = (mag_ff == '0) ||
                    ((mag_shr[ACC_W-1:THR_W] == '0) && (mag_shr[THR_W-1:0] < thr_ff));

   assign rem_ge = (rem_ff >= dsh_ff);

   // sign and saturation of the quotient
   always_comb begin
      if (!neg_ff) begin
         res_in = (big_ff || q_ff[Q_W-1]) ? mtxinv_pkg::SAT_MAX : q_ff;
      end else begin
         res_in = (big_ff || (q_ff > mtxinv_pkg::SAT_MIN)) ? mtxinv_pkg::SAT_MIN
                                                          : (~q_ff + 1'b1);
      end
   end

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= mtxinv_pkg::THR_RESET;
      end else if (csr_write_enable) begin
         thr_ff <= csr_write_data;
      end
   end

   // command execution
   always_ff @(posedge clock) begin
      case (cmd.op)
         mtxinv_pkg::DP_CLR: acc_ff <= '0;
         mtxinv_pkg::DP_LDXE: x_ff <= {{(X_W-ELEM_W){rdata[ELEM_W-1]}}, rdata};
         mtxinv_pkg::DP_LDXM: x_ff <= {{(X_W-MINOR_W){minor_sel[MINOR_W-1]}}, minor_sel};
         mtxinv_pkg::DP_LDXC: x_ff <= {{(X_W-COF_W){cof_sel[COF_W-1]}}, cof_sel};
         mtxinv_pkg::DP_MUL: begin
            prod_ff    <= prod_in;
            limb_sh_ff <= cmd.limb;
            sub_ff     <= cmd.sub;
         end
         mtxinv_pkg::DP_ACC: acc_ff <= acc_in;
         mtxinv_pkg::DP_STM: minor_ff[cmd.idx] <= acc_ff[MINOR_W-1:0];
         mtxinv_pkg::DP_STC: cof_ff[cmd.idx] <= acc_ff[COF_W-1:0];
         mtxinv_pkg::DP_STD: det_ff <= acc_ff;
         mtxinv_pkg::DP_MAG: begin
            mag_ff    <= det_abs;
            detneg_ff <= det_ff[ACC_W-1];
         end
         mtxinv_pkg::DP_TEST: sing_ff <= sing_in;
         mtxinv_pkg::DP_DIV_INIT: begin
            rem_ff <= DIV_W'(cof_abs) << NUM_SH;
            dsh_ff <= DIV_W'(mag_ff) << Q_W;
            neg_ff <= cof_sel[COF_W-1] ^ detneg_ff;
         end
         mtxinv_pkg::DP_DIV_CHK: begin
            big_ff <= rem_ge;
            dsh_ff <= dsh_ff >> 1;
         end
         mtxinv_pkg::DP_DIV_STEP: begin
            if (rem_ge) begin
               rem_ff <= rem_ff - dsh_ff;
            end
            q_ff   <= {q_ff[Q_W-2:0], rem_ge};
            dsh_ff <= dsh_ff >> 1;
         end
         mtxinv_pkg::DP_OUT_DIV: begin
            res_ff   <= res_in;
            rsing_ff <= 1'b0;
            last_ff  <= cmd.last;
         end
         mtxinv_pkg::DP_OUT_ECHO: begin
            res_ff   <= rdata;
            rsing_ff <= 1'b1;
            last_ff  <= cmd.last;
         end
         default: ;
      endcase
   end

   assign status.singular    = sing_ff;
   assign rsp_result_value   = res_ff;
   assign rsp_is_singular    = rsing_ff;
   assign rsp_last_of_matrix = last_ff;

endmodule

// ----- src/mtxinv_ctrl.sv -----
// ----------------------------------------------------------------------------
// mtxinv_ctrl: controller of the 4x4 inverse
// Loads elements, steps the cofactor microprogram, then sequences the
// singular test, the per-result divisions or echoes, and the output handshake.
// ----------------------------------------------------------------------------
module mtxinv_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output mtxinv_pkg::dp_cmd_type    cmd,
   input  mtxinv_pkg::dp_status_type status
);

   typedef enum logic [3:0] {
      S_LOAD,
      S_FETCH,
      S_EXEC,
      S_MUL,
      S_ACC,
      S_MAG,
      S_TEST,
      S_NEXT,
      S_ECHO,
      S_DINIT,
      S_DCHK,
      S_DSTEP,
      S_DFMT,
      S_OUT
   } ctl_state_type;

   ctl_state_type                      state_ff;
   logic [mtxinv_pkg::ADDR_W-1:0]      cnt_ff;
   logic [mtxinv_pkg::PC_W-1:0]        pc_ff;
   mtxinv_pkg::prog_op_type            op_ff;
   logic [1:0]                         limb_ff;
   logic [4:0]                         step_ff;
   logic [mtxinv_pkg::ADDR_W-1:0]      k_ff;
   logic                               ready_ff;
   logic                               valid_ff;
   mtxinv_pkg::prog_op_type            fetch_op;

   assign fetch_op = mtxinv_pkg::prog_op(pc_ff);

   // datapath commands per state
   always_comb begin
      cmd           = '0;
      cmd.op        = mtxinv_pkg::DP_NONE;
      cmd.ram_waddr = cnt_ff;
      cmd.idx       = op_ff.idx;
      cmd.sub       = op_ff.sub;
      cmd.limb      = limb_ff;
      cmd.top       = (limb_ff == op_ff.last_limb);
      cmd.last      = &k_ff;
      case (state_ff)
         S_LOAD:  cmd.ram_we = req_valid & ready_ff;
         S_FETCH: begin
            cmd.ram_re    = 1'b1;
            cmd.ram_raddr = fetch_op.addr;
         end
         S_EXEC: begin
            case (op_ff.kind)
               mtxinv_pkg::PK_CLR:  cmd.op = mtxinv_pkg::DP_CLR;
               mtxinv_pkg::PK_LDXE: cmd.op = mtxinv_pkg::DP_LDXE;
               mtxinv_pkg::PK_LDXM: cmd.op = mtxinv_pkg::DP_LDXM;
               mtxinv_pkg::PK_LDXC: cmd.op = mtxinv_pkg::DP_LDXC;
               mtxinv_pkg::PK_STM:  cmd.op = mtxinv_pkg::DP_STM;
               mtxinv_pkg::PK_STC:  cmd.op = mtxinv_pkg::DP_STC;
               mtxinv_pkg::PK_STD:  cmd.op = mtxinv_pkg::DP_STD;
               default:             cmd.op = mtxinv_pkg::DP_NONE;
            endcase
         end
         S_MUL:  cmd.op = mtxinv_pkg::DP_MUL;
         S_ACC:  cmd.op = mtxinv_pkg::DP_ACC;
         S_MAG:  cmd.op = mtxinv_pkg::DP_MAG;
         S_TEST: cmd.op = mtxinv_pkg::DP_TEST;
         S_NEXT: begin
            cmd.ram_re    = 1'b1;
            cmd.ram_raddr = k_ff;
         end
         S_ECHO: cmd.op = mtxinv_pkg::DP_OUT_ECHO;
         S_DINIT: begin
            // result (r,c) is cofactor (c,r)
            cmd.op  = mtxinv_pkg::DP_DIV_INIT;
            cmd.idx = {k_ff[1:0], k_ff[3:2]};
         end
         S_DCHK:  cmd.op = mtxinv_pkg::DP_DIV_CHK;
         S_DSTEP: cmd.op = mtxinv_pkg::DP_DIV_STEP;
         S_DFMT:  cmd.op = mtxinv_pkg::DP_OUT_DIV;
         default: cmd.op = mtxinv_pkg::DP_NONE;
      endcase
   end

   // state and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         cnt_ff   <= '0;
         pc_ff    <= '0;
         op_ff    <= '0;
         limb_ff  <= '0;
         step_ff  <= '0;
         k_ff     <= '0;
         ready_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_LOAD: begin
               if (req_valid && ready_ff) begin
                  cnt_ff <= cnt_ff + 1'b1;
                  if (&cnt_ff) begin
                     ready_ff <= 1'b0;
                     pc_ff    <= '0;
                     state_ff <= S_FETCH;
                  end
               end
            end
            S_FETCH: begin
               op_ff    <= fetch_op;
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               case (op_ff.kind)
                  mtxinv_pkg::PK_MAC: begin
                     limb_ff  <= '0;
                     state_ff <= S_MUL;
                  end
                  mtxinv_pkg::PK_END: state_ff <= S_MAG;
                  default: begin
                     pc_ff    <= pc_ff + 1'b1;
                     state_ff <= S_FETCH;
                  end
               endcase
            end
            S_MUL: state_ff <= S_ACC;
            S_ACC: begin
               if (limb_ff == op_ff.last_limb) begin
                  pc_ff    <= pc_ff + 1'b1;
                  state_ff <= S_FETCH;
               end else begin
                  limb_ff  <= limb_ff + 1'b1;
                  state_ff <= S_MUL;
               end
            end
            S_MAG: state_ff <= S_TEST;
            S_TEST: begin
               k_ff     <= '0;
               state_ff <= S_NEXT;
            end
            S_NEXT: state_ff <= status.singular ? S_ECHO : S_DINIT;
            S_ECHO: begin
               valid_ff <= 1'b1;
               state_ff <= S_OUT;
            end
            S_DINIT: state_ff <= S_DCHK;
            S_DCHK: begin
               step_ff  <= '0;
               state_ff <= S_DSTEP;
            end
            S_DSTEP: begin
               step_ff <= step_ff + 1'b1;
               if (&step_ff) begin
                  state_ff <= S_DFMT;
               end
            end
            S_DFMT: begin
               valid_ff <= 1'b1;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (rsp_ready) begin
                  valid_ff <= 1'b0;
                  if (&k_ff) begin
                     ready_ff <= 1'b1;
                     state_ff <= S_LOAD;
                  end else begin
                     k_ff     <= k_ff + 1'b1;
                     state_ff <= S_NEXT;
                  end
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assign req_ready = ready_ff;
   assign rsp_valid = valid_ff;

endmodule

// ----- bench/mtxinv_checker.sv -----
// ----------------------------------------------------------------------------
// mtxinv_checker: result predictor and comparator for matrix_inverse_4x4
// Watches the element and result channels, collects each group of sixteen
// accepted elements, computes the expected inverse (or echo when singular)
// with exact wide arithmetic and compares every result transaction in order.
// ----------------------------------------------------------------------------
module mtxinv_checker #(
   parameter int FRAC_BITS = mtxinv_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic signed [mtxinv_pkg::ELEM_W-1:0] req_element_value,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [mtxinv_pkg::Q_W-1:0]    rsp_result_value,
   input  logic                                 rsp_is_singular,
   input  logic                                 rsp_last_of_matrix,
   input  logic                                 csr_write_enable,
   input  logic [mtxinv_pkg::THR_W-1:0]         csr_write_data,
   output int                                   fail_count,
   output int                                   pending_count
);

   typedef logic signed [255:0] wide_type;

   typedef struct packed {
      logic [mtxinv_pkg::Q_W-1:0] value;
      logic                       singular;
      logic                       last;
   } inv_result_type;

   logic [mtxinv_pkg::ELEM_W-1:0] matrix_elems[mtxinv_pkg::ELEMS];
   logic [3:0]                    elem_count_ff;
   logic [mtxinv_pkg::THR_W-1:0]  threshold_ff;
   inv_result_type                expected_q[$];

   function automatic wide_type el(input int r, input int c);
      el = wide_type'($signed(matrix_elems[r * 4 + c]));
   endfunction

   // signed 3x3 cofactor of entry (r,c)
   function automatic wide_type cofactor_of(input int r, input int c);
      wide_type m[3][3];
      wide_type d;
      int a, b;
      a = 0;
      for (int i = 0; i < 4; i++) begin
         if (i != r) begin
            b = 0;
            for (int j = 0; j < 4; j++) begin
               if (j != c) begin
                  m[a][b] = el(i, j);
                  b++;
               end
            end
            a++;
         end
      end
      d = m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
        - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
        + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
      cofactor_of = ((r + c) % 2 == 1) ? -d : d;
   endfunction

   // full 16-result prediction for the stored matrix
   task automatic predict_inverse();
      wide_type cof[4][4];
      wide_type det, mag, scaled, cmag, quot;
      logic  singular, neg;
      inv_result_type res;
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++)
            cof[i][j] = cofactor_of(i, j);
      det = 0;
      for (int j = 0; j < 4; j++) det += cof[0][j] * el(0, j);
      mag      = (det < 0) ? -det : det;
      scaled   = mag >>> (3 * FRAC_BITS);
      singular = (det == 0) || (scaled < wide_type'(threshold_ff));
      for (int k = 0; k < 16; k++) begin
         res.singular = singular;
         res.last     = (k == 15);
         if (singular) begin
            res.value = matrix_elems[k];
         end else begin
            neg  = (cof[k % 4][k / 4] < 0) != (det < 0);
            cmag = (cof[k % 4][k / 4] < 0) ? -cof[k % 4][k / 4] : cof[k % 4][k / 4];
            quot = (cmag <<< (2 * FRAC_BITS)) / mag;
            if (!neg)
               res.value = (quot > 64'sh7FFF_FFFF) ? mtxinv_pkg::SAT_MAX : quot[31:0];
            else
               res.value = (quot > 64'sh8000_0000) ? mtxinv_pkg::SAT_MIN : -quot[31:0];
         end
         expected_q.push_back(res);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         elem_count_ff <= '0;
         threshold_ff  <= mtxinv_pkg::THR_RESET;
         fail_count    <= 0;
         expected_q.delete();
      end else begin
         if (csr_write_enable) threshold_ff <= csr_write_data;
         // element transaction
         if (req_valid && req_ready) begin
            matrix_elems[elem_count_ff] = req_element_value;
            if (elem_count_ff == 4'd15) predict_inverse();
            elem_count_ff <= elem_count_ff + 4'd1;
         end
         // result transaction
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result value=%h sing=%b last=%b", $time,
                        rsp_result_value, rsp_is_singular, rsp_last_of_matrix);
               fail_count <= fail_count + 1;
            end else begin
               inv_result_type e;
               e = expected_q.pop_front();
               if (e.value !== rsp_result_value || e.singular !== rsp_is_singular ||
                   e.last !== rsp_last_of_matrix) begin
                  $display("%0t: expected %h/%b/%b, actual %h/%b/%b",
                           $time, e.value, e.singular, e.last, rsp_result_value,
                           rsp_is_singular, rsp_last_of_matrix);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      // outstanding predictions
      pending_count <= expected_q.size();
   end
endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for matrix_inverse_4x4
// Feeds directed and random 4x4 matrices under several singularity
// thresholds with random idling on both channels; the checker predicts.
// ----------------------------------------------------------------------------
module tb_top;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic signed [mtxinv_pkg::ELEM_W-1:0] req_element_value = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic signed [mtxinv_pkg::Q_W-1:0]    rsp_result_value;
   logic                                 rsp_is_singular;
   logic                                 rsp_last_of_matrix;
   logic                                 csr_write_enable = 1'b0;
   logic [mtxinv_pkg::THR_W-1:0]         csr_write_data = '0;
   int                                   fail_count;
   int                                   pending_count;
   logic                                 calm = 1'b0;

   always #5 clock = ~clock;

   matrix_inverse_4x4 u_dut (.*);

   mtxinv_checker u_checker (.*);

   // result side stalls in bursts
   always @(negedge clock) begin
      if (!calm && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      rsp_ready <= 1'b1;
   end

   // valid stays high between back-to-back elements
   task automatic send_elem(input logic [31:0] v);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_element_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_matrix(input logic [31:0] m[16]);
      for (int k = 0; k < 16; k++) send_elem(m[k]);
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   // scaled identity plus small random perturbation, small or full random, or full random with a zero first row
   task automatic random_matrix(input int kind);
      logic [31:0] m[16];
      for (int k = 0; k < 16; k++) begin
         case (kind)
            0: m[k] = $urandom();
            1: m[k] = ((k % 5 == 0) ? 32'h0001_0000 * $urandom_range(1, 8) : 32'h0)
                      + $signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000;
            2: m[k] = $signed($urandom_range(0, 32'h40_0000)) - 32'sh20_0000;
            default: m[k] = (k < 4) ? 32'h0 : $urandom();
         endcase
      end
      send_matrix(m);
   endtask

   task automatic drain_and_set(input logic [mtxinv_pkg::THR_W-1:0] thr);
      while (pending_count != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= thr;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [31:0] m[16];
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // identity
      for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 32'h0001_0000 : 32'h0;
      send_matrix(m);
      // extremes on the diagonal: +1 and -1 give saturation, the other two are large
      for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 32'h0000_0001 : 32'h0;
      m[5] = 32'h7FFF_FFFF; m[10] = 32'h8000_0000; m[15] = 32'hFFFF_FFFF;
      send_matrix(m);
      // zero determinant with threshold zero
      drain_and_set('0);
      for (int k = 0; k < 16; k++) m[k] = 32'h8000_0000;
      send_matrix(m);
      random_matrix(1);
      drain_and_set(31'h7FFF_FFFF);
      random_matrix(0);
      drain_and_set(31'd1);
      random_matrix(2);
      drain_and_set(31'd3);
      calm = 1'b1;
      random_matrix(1);
      while (pending_count != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0)
         $display("[matrix_inverse_4x4] OK");
      else
         $display("[matrix_inverse_4x4] ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("[matrix_inverse_4x4] ERROR");
      $finish;
   end
endmodule

// ----- matrix_inverse_4x4.f -----
src/mtxinv_pkg.sv
src/mtxinv_ram.sv
src/mtxinv_dp.sv
src/mtxinv_ctrl.sv
src/matrix_inverse_4x4.sv
bench/mtxinv_checker.sv
bench/tb_top.sv
